### design/fps_pkg.sv
// Shared types and constants of the four-position switch debouncer.
package fps_pkg;

	localparam int MV_W     = 13;
	localparam int HYST_W   = 10;
	localparam int DEB_W    = 32;
	localparam int NOW_W    = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int SMV_W    = 15;

	// floor(x / 6) == (x * DIV6_MUL) >> DIV6_SHIFT for every 13-bit x
	localparam int DIV6_MUL   = 43691;
	localparam int DIV6_SHIFT = 18;

	localparam logic [MV_W-1:0]   SUPPLY_RST = 13'd3300;
	localparam logic [HYST_W-1:0] HYST_RST   = 10'd100;
	localparam logic [DEB_W-1:0]  DEB_RST    = 32'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SUPPLY   = 2'd0,
		REG_HYST     = 2'd1,
		REG_DEBOUNCE = 2'd2
	} reg_idx_t;

	typedef logic [1:0] pos_t;
	typedef logic signed [SMV_W-1:0] smv_t;

	typedef enum logic {
		PH_STABLE  = 1'b0,
		PH_CONFIRM = 1'b1
	} phase_t;

	// window edges around the three thresholds
	typedef struct packed {
		smv_t lo1;
		smv_t hi1;
		smv_t lo3;
		smv_t hi3;
		smv_t lo5;
		smv_t hi5;
	} bounds_t;

	typedef struct packed {
		logic hit;
		pos_t pos;
	} match_t;

	typedef struct packed {
		pos_t confirmed_position;
		logic pending;
		pos_t pending_position;
	} result_t;

endpackage

### design/fps_thresh.sv
// Window edge registers derived from the supply and hysteresis settings.
module fps_thresh (
	input  logic                         clk,
	input  logic [fps_pkg::MV_W-1:0]     supply_mv,
	input  logic [fps_pkg::HYST_W-1:0]   hysteresis_mv,
	output fps_pkg::bounds_t             bounds
);
	import fps_pkg::*;

	localparam int PROD_W = 29;

	logic [PROD_W-1:0] prod;
	logic [10:0]       t1;
	logic [11:0]       t3;
	logic [MV_W-1:0]   t1x6;
	logic              rem_nz;
	logic [MV_W-1:0]   t5;
	logic [8:0]        half_h;
	bounds_t           bounds_d;
	bounds_t           bounds_q;

	assign prod   = PROD_W'(supply_mv) * PROD_W'(DIV6_MUL);
	assign t1     = prod[PROD_W-1:DIV6_SHIFT];
	assign t3     = supply_mv[MV_W-1:1];
	assign t1x6   = MV_W'({t1, 2'b00}) + MV_W'({t1, 1'b0});
	assign rem_nz = (supply_mv != t1x6);
	// floor(5s/6) = s - ceil(s/6)
	assign t5     = supply_mv - MV_W'(t1) - MV_W'(rem_nz);
	assign half_h = hysteresis_mv[HYST_W-1:1];

	always_comb begin
		bounds_d.lo1 = smv_t'(t1) - smv_t'(half_h);
		bounds_d.hi1 = smv_t'(t1) + smv_t'(half_h);
		bounds_d.lo3 = smv_t'(t3) - smv_t'(half_h);
		bounds_d.hi3 = smv_t'(t3) + smv_t'(half_h);
		bounds_d.lo5 = smv_t'(t5) - smv_t'(half_h);
		bounds_d.hi5 = smv_t'(t5) + smv_t'(half_h);
	end

	always_ff @(posedge clk) begin
		bounds_q <= bounds_d;
	end

	assign bounds = bounds_q;

endmodule

### design/fps_classify.sv
// Classifies one voltage sample into a switch position or the dead band.
module fps_classify (
	input  logic [fps_pkg::MV_W-1:0] sample_mv,
	input  logic                     sense_enable,
	input  fps_pkg::bounds_t         bounds,
	output fps_pkg::match_t          match
);
	import fps_pkg::*;

	smv_t v;

	assign v = sense_enable ? smv_t'(sample_mv) : smv_t'(0);

	always_comb begin
		match.hit = 1'b1;
		match.pos = 2'd0;
		if ($signed(v) < $signed(bounds.lo1)) begin
			match.pos = 2'd0;
		end else if ($signed(v) > $signed(bounds.hi1) && $signed(v) < $signed(bounds.lo3)) begin
			match.pos = 2'd1;
		end else if ($signed(v) > $signed(bounds.hi3) && $signed(v) < $signed(bounds.lo5)) begin
			match.pos = 2'd2;
		end else if ($signed(v) > $signed(bounds.hi5)) begin
			match.pos = 2'd3;
		end else begin
			match.hit = 1'b0;
		end
	end

endmodule

### design/fps_track.sv
// Debounce state machine and result register.
module fps_track #(
	parameter int TIME_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  fps_pkg::match_t           match,
	input  logic [fps_pkg::NOW_W-1:0] now_ms,
	input  logic [fps_pkg::DEB_W-1:0] debounce_ms,
	input  logic                      out_ready,
	output logic                      advance,
	output logic                      out_valid,
	output fps_pkg::result_t          result
);
	import fps_pkg::*;

	typedef logic [TIME_BITS-1:0] time_t;

	phase_t  mode_q, mode_n;
	pos_t    pos_q, pos_n;
	pos_t    conf_q, conf_n;
	time_t   start_q, start_n;
	time_t   now_t;
	time_t   limit;
	logic    out_valid_q;
	result_t result_q, result_d;

	assign now_t   = time_t'(now_ms);
	assign limit   = start_q + time_t'(debounce_ms);
	assign advance = in_valid && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		mode_n  = mode_q;
		pos_n   = pos_q;
		conf_n  = conf_q;
		start_n = start_q;
		case (mode_q)
			PH_STABLE: begin
				conf_n = pos_q;
				if (match.hit && match.pos != pos_q) begin
					mode_n  = PH_CONFIRM;
					pos_n   = match.pos;
					start_n = now_t;
				end
			end
			PH_CONFIRM: begin
				if (match.hit) begin
					if (match.pos == conf_q) begin
						mode_n = PH_STABLE;
						pos_n  = conf_q;
					end else if (match.pos != pos_q) begin
						pos_n   = match.pos;
						start_n = now_t;
					end else if (now_t > limit) begin
						mode_n = PH_STABLE;
					end
				end
			end
			default: begin
				mode_n = PH_STABLE;
			end
		endcase
	end

	// result word
	always_comb begin
		result_d.confirmed_position = conf_n;
		result_d.pending            = (mode_n == PH_CONFIRM);
		result_d.pending_position   = (mode_n == PH_CONFIRM) ? pos_n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= PH_STABLE;
			pos_q       <= 2'd0;
			conf_q      <= 2'd0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q  <= mode_n;
				pos_q   <= pos_n;
				conf_q  <= conf_n;
				start_q <= start_n;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

`ifndef NO_ASSERTIONS
	a_confirm_differs: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == PH_CONFIRM |-> pos_q != conf_q)
		else $error("confirming the already confirmed position");

	a_conf_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(conf_q) && $stable(mode_q) && $stable(pos_q))
		else $error("debounce state moved without a word");

	a_leave_confirm: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_q == PH_CONFIRM && mode_n == PH_STABLE |->
			match.hit && (match.pos == conf_q || match.pos == pos_q))
		else $error("left confirmation without a matching sample");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced word did not reach the result register");
`endif

endmodule

### design/four_position_switch_debouncer_core.sv
// Top level of the four-position switch debouncer: ports, settings, input stage.
// Data path: an accepted word sits in the input register, is classified and updates the state
//   into the result register, and leaves from there once m_tready takes it.
// Throughput: one word per cycle; the result register holds while m_tready is low.
// Supply and hysteresis writes pass the settings registers, then the window edge registers.
// Reset (arst_n low, asynchronous): stable at position 0, settings to defaults.
module four_position_switch_debouncer_core #(
	parameter int TIME_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [12:0] sample_mv, [13] sense_enable, [45:14] now_ms, [47:46] zero
	input  logic [47:0]                         s_tdata,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] confirmed_position, [2] pending, [4:3] pending_position, [7:5] zero
	output logic [7:0]                          m_tdata,
	// settings write port
	input  logic                                cfg_we,
	input  logic [fps_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [fps_pkg::CFG_W-1:0]           cfg_data
);
	import fps_pkg::*;

	// settings
	logic [MV_W-1:0]   supply_q;
	logic [HYST_W-1:0] hyst_q;
	logic [DEB_W-1:0]  deb_q;

	// input stage
	logic              valid_s1;
	logic [MV_W-1:0]   sample_s1;
	logic              en_s1;
	logic [NOW_W-1:0]  now_s1;

	bounds_t bounds;
	match_t  match;
	result_t result;
	logic    advance;
	logic    s_accept;

	// Take settings writes as they come; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= SUPPLY_RST;
			hyst_q   <= HYST_RST;
			deb_q    <= DEB_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_SUPPLY:   supply_q <= cfg_data[MV_W-1:0];
				REG_HYST:     hyst_q   <= cfg_data[HYST_W-1:0];
				REG_DEBOUNCE: deb_q    <= cfg_data[DEB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage frees up whenever its word moves on to the result register.
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Unpack and hold the accepted word.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			sample_s1 <= s_tdata[12:0];
			en_s1     <= s_tdata[13];
			now_s1    <= s_tdata[45:14];
		end
	end

	fps_thresh u_thresh (
		.clk           (clk),
		.supply_mv     (supply_q),
		.hysteresis_mv (hyst_q),
		.bounds        (bounds)
	);

	fps_classify u_classify (
		.sample_mv    (sample_s1),
		.sense_enable (en_s1),
		.bounds       (bounds),
		.match        (match)
	);

	fps_track #(
		.TIME_BITS (TIME_BITS)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s1),
		.match       (match),
		.now_ms      (now_s1),
		.debounce_ms (deb_q),
		.out_ready   (m_tready),
		.advance     (advance),
		.out_valid   (m_tvalid),
		.result      (result)
	);

	// Pack the result word, lowest field first.
	assign m_tdata = {3'b000, result.pending_position, result.pending,
		result.confirmed_position};

`ifndef NO_ASSERTIONS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_stage_filled: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> valid_s1)
		else $error("accepted word lost from the input stage");

	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance && !s_accept |=> valid_s1)
		else $error("input word dropped while stalled");
`endif

endmodule

### tb/switch_debounce_checker.sv
// Checker for the four-position switch debouncer: predicts each result word and compares it.
`timescale 1ns / 100ps

module switch_debounce_checker #(
	parameter int TIME_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [47:0]                   s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [7:0]                    m_tdata,
	input  logic                          cfg_we,
	input  logic [fps_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [fps_pkg::CFG_W-1:0]     cfg_data,
	output int                            failures,
	output int                            outstanding,
	output int                            results_seen,
	output int                            positions_debounced
);
	import fps_pkg::*;

	localparam logic [63:0] TMASK = (TIME_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
		((64'd1 << TIME_BITS) - 64'd1);

	// shadow settings
	logic [MV_W-1:0]   supply_mv;
	logic [HYST_W-1:0] hyst_mv;
	logic [DEB_W-1:0]  debounce_ms;

	// shadow switch state
	phase_t      mode;
	pos_t        phase_pos;
	pos_t        confirmed;
	logic [63:0] confirm_start;

	result_t predicted_results[$];
	result_t oldest;

	function automatic match_t classify_mv(input logic [MV_W-1:0] v);
		int s, h, t1, t3, t5, vi;
		match_t m;
		s  = int'(supply_mv);
		h  = int'(hyst_mv) / 2;
		t1 = s / 6;
		t3 = (3 * s) / 6;
		t5 = (5 * s) / 6;
		vi = int'(v);
		m.hit = 1'b1;
		if (vi < t1 - h)
			m.pos = 2'd0;
		else if (vi > t1 + h && vi < t3 - h)
			m.pos = 2'd1;
		else if (vi > t3 + h && vi < t5 - h)
			m.pos = 2'd2;
		else if (vi > t5 + h)
			m.pos = 2'd3;
		else begin
			m.hit = 1'b0;
			m.pos = 2'd0;
		end
		return m;
	endfunction

	// advance the shadow state by one sample and return the result word it produces
	function automatic result_t debounce_next(input logic [MV_W-1:0] mv, input logic en,
			input logic [31:0] now_in);
		match_t      m;
		logic [63:0] now, limit;
		result_t     r;
		now = 64'(now_in) & TMASK;
		m   = classify_mv(en ? mv : '0);
		if (mode == PH_STABLE) begin
			confirmed = phase_pos;
			if (m.hit && m.pos != phase_pos) begin
				mode          = PH_CONFIRM;
				phase_pos     = m.pos;
				confirm_start = now;
			end
		end else if (m.hit) begin
			if (m.pos == confirmed) begin
				mode      = PH_STABLE;
				phase_pos = confirmed;
			end else if (m.pos != phase_pos) begin
				phase_pos     = m.pos;
				confirm_start = now;
			end else begin
				limit = (confirm_start + (64'(debounce_ms) & TMASK)) & TMASK;
				if (now > limit) begin
					mode = PH_STABLE;
					positions_debounced++;
				end
			end
		end
		r.confirmed_position = confirmed;
		r.pending            = (mode == PH_CONFIRM);
		r.pending_position   = (mode == PH_CONFIRM) ? phase_pos : 2'd0;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			failures++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_mv     = SUPPLY_RST;
			hyst_mv       = HYST_RST;
			debounce_ms   = DEB_RST;
			mode          = PH_STABLE;
			phase_pos     = 2'd0;
			confirmed     = 2'd0;
			confirm_start = '0;
			predicted_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_SUPPLY:   supply_mv   = cfg_data[MV_W-1:0];
					REG_HYST:     hyst_mv     = cfg_data[HYST_W-1:0];
					REG_DEBOUNCE: debounce_ms = cfg_data[DEB_W-1:0];
					default: ;
				endcase
			end
			// pop before push: a word accepted now cannot leave in the same cycle
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (predicted_results.size() == 0) begin
					failures++;
					$display("%0t: unexpected result word %h, expected none", $time,
						m_tdata);
				end else begin
					oldest = predicted_results.pop_front();
					check_field("confirmed_position", oldest.confirmed_position, m_tdata[1:0]);
					check_field("pending", oldest.pending, m_tdata[2]);
					check_field("pending_position", oldest.pending_position, m_tdata[4:3]);
				end
			end
			if (s_tvalid && s_tready)
				predicted_results.push_back(debounce_next(s_tdata[12:0], s_tdata[13],
					s_tdata[45:14]));
		end
		outstanding = predicted_results.size();
	end

	initial begin
		failures            = 0;
		outstanding         = 0;
		results_seen        = 0;
		positions_debounced = 0;
	end

endmodule

### tb/tb_four_position_switch_debouncer_core.sv
// Testbench top for the four-position switch debouncer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_four_position_switch_debouncer_core;
	import fps_pkg::*;

	localparam int TIME_BITS      = 32;
	localparam int STALL_LIMIT    = 3000;  // far above the longest receiver hold-off
	localparam int RX_HOLD_CYCLES = 150;
	localparam int ITEMS_PER_SET  = 130;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // no register behind this index

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// [12:0] sample_mv, [13] sense_enable, [45:14] now_ms, [47:46] zero
	logic [47:0]          s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	// [1:0] confirmed_position, [2] pending, [4:3] pending_position, [7:5] zero
	logic [7:0]           m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	int failures, outstanding, results_seen, positions_debounced;

	// stimulus-side copy of the window settings, used only to aim samples at a position
	int          cur_supply = 3300;
	int          cur_hyst   = 100;
	logic [31:0] clock_ms;
	int          samples_sent = 0;
	int          settings_used = 0;
	int          stall_cycles = 0;

	bit no_idle      = 1'b0;
	bit rx_hold_req  = 1'b0;
	bit rx_hold_done = 1'b0;

	four_position_switch_debouncer_core #(
		.TIME_BITS(TIME_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	switch_debounce_checker #(
		.TIME_BITS(TIME_BITS)
	) checker_i (
		.clk                 (clk),
		.arst_n              (arst_n),
		.s_tvalid            (s_tvalid),
		.s_tready            (s_tready),
		.s_tdata             (s_tdata),
		.m_tvalid            (m_tvalid),
		.m_tready            (m_tready),
		.m_tdata             (m_tdata),
		.cfg_we              (cfg_we),
		.cfg_idx             (cfg_idx),
		.cfg_data            (cfg_data),
		.failures            (failures),
		.outstanding         (outstanding),
		.results_seen        (results_seen),
		.positions_debounced (positions_debounced)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run once no word has moved on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("%0t: watchdog, no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result receiver: random backpressure, one long hold-off on request, none while
	// no_idle is set. Changes happen at the falling edge only.
	initial begin
		m_tready = 1'b0;
		@(negedge clk);
		forever begin
			if (rx_hold_req && !rx_hold_done) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_done = 1'b1;
			end else begin
				m_tready <= no_idle || ($urandom_range(99) >= 35);
				@(negedge clk);
			end
		end
	end

	// Pick a voltage inside the window of one position under the current settings.
	// Hit the window edges now and then; fall back to any voltage when the window is empty.
	function automatic logic [MV_W-1:0] pick_mv(input int pos);
		int t1, t3, t5, h, lo, hi;
		t1 = cur_supply / 6;
		t3 = (3 * cur_supply) / 6;
		t5 = (5 * cur_supply) / 6;
		h  = cur_hyst / 2;
		case (pos)
			0: begin
				lo = 0;
				hi = t1 - h - 1;
			end
			1: begin
				lo = t1 + h + 1;
				hi = t3 - h - 1;
			end
			2: begin
				lo = t3 + h + 1;
				hi = t5 - h - 1;
			end
			default: begin
				lo = t5 + h + 1;
				hi = 8191;
			end
		endcase
		if (lo < 0)
			lo = 0;
		if (hi > 8191)
			hi = 8191;
		if (lo > hi)
			return MV_W'($urandom_range(8191));
		if ($urandom_range(9) < 3)
			return MV_W'(($urandom_range(1) != 0) ? lo : hi);
		return MV_W'(lo + $urandom_range(hi - lo));
	endfunction

	// Offer one sample word and hold it until accepted. Call and return at a falling edge.
	task automatic send_sample(input logic [MV_W-1:0] mv, input logic en,
			input logic [31:0] now);
		if (!(no_idle || (rx_hold_req && !rx_hold_done)) && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		s_tdata  <= {2'b00, now, en, mv};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		samples_sent++;
	endtask

	// Stop offering and hold until every predicted word has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Drain, then write all three registers. With dirty set, fill the unused upper
	// data bits with junk that the block must drop.
	task automatic apply_settings(input int supply, input int hyst, input logic [31:0] deb,
			input bit dirty);
		logic [31:0] junk;
		wait_drained();
		junk = dirty ? $urandom() : 32'd0;
		write_setting(REG_SUPPLY, {junk[31:MV_W], MV_W'(supply)});
		write_setting(REG_HYST, {junk[31:HYST_W], HYST_W'(hyst)});
		write_setting(REG_DEBOUNCE, deb);
		cur_supply = supply;
		cur_hyst   = hyst;
		settings_used++;
		// let the new window edges settle before the next sample
		repeat (2) @(negedge clk);
	endtask

	initial begin
		int          n, pos, len, supply, hyst;
		logic [31:0] deb;
		bit          dirty;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		cfg_we   = 1'b0;
		cfg_idx  = REG_SUPPLY;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at reset settings: thresholds 550/1650/2750, half band 50,
		// no debounce time.
		send_sample(13'd0, 1'b1, 32'd0);             // settle at position zero
		send_sample(13'd8191, 1'b1, 32'hFFFF_FFFF);  // full scale starts confirming 3
		send_sample(13'd8191, 1'b1, 32'd0);          // time wrapped below start: still pending
		send_sample(13'd100, 1'b1, 32'd1);           // back at the confirmed position
		send_sample(13'd1000, 1'b1, 32'd2);          // start confirming position 1
		send_sample(13'd2000, 1'b1, 32'd3);          // third position restarts on 2
		send_sample(13'd550, 1'b1, 32'd4);           // dead bands around each threshold
		send_sample(13'd1650, 1'b1, 32'd4);
		send_sample(13'd2750, 1'b1, 32'd4);
		send_sample(13'd2000, 1'b1, 32'd4);          // past the deadline: stable at 2
		send_sample(13'd2000, 1'b1, 32'd4);          // confirmed output follows a step late
		send_sample(13'd8191, 1'b0, 32'd5);          // disabled sense reads as 0 mV
		send_sample(13'd3000, 1'b1, 32'd6);
		send_sample(13'd3000, 1'b1, 32'd6);          // equal to the deadline is not enough
		send_sample(13'd3000, 1'b1, 32'd7);
		send_sample(13'd599, 1'b1, 32'd8);           // just inside and just outside the band edges
		send_sample(13'd601, 1'b1, 32'd9);
		send_sample(13'd499, 1'b1, 32'd10);
		send_sample(13'd2699, 1'b1, 32'd11);
		send_sample(13'd2801, 1'b1, 32'd12);

		// Widest band, full supply, longest debounce: start plus debounce wraps, so a
		// repeat of the pending position confirms at once.
		apply_settings(8191, 1023, 32'hFFFF_FFFF, 1'b0);
		write_setting(REG_UNUSED, 32'hFFFF_FFFF);    // ignored index
		send_sample(13'd0, 1'b1, 32'd100);
		send_sample(13'd0, 1'b1, 32'd100);
		send_sample(13'd8191, 1'b1, 32'd0);
		send_sample(13'd8191, 1'b1, 32'd0);
		send_sample(13'd8191, 1'b1, 32'd1);

		// Random part: one block of samples per setting. Most samples come as runs that
		// hold one position while time advances, so debouncing completes; the rest is
		// noise across the whole field range.
		for (int set = 0; set < 8; set++) begin
			dirty = set[0];
			case (set)
				0: begin
					supply = 0;
					hyst   = 1023;
					deb    = $urandom_range(0, 8);
				end
				1: begin
					supply = 8191;
					hyst   = 0;
					deb    = $urandom_range(0, 8);
				end
				2: begin
					supply = $urandom_range(600, 8191);
					hyst   = 1;
					deb    = $urandom_range(0, 20);
				end
				3: begin
					supply = $urandom_range(600, 8191);
					hyst   = $urandom_range(0, 300);
					deb    = 32'hFFFF_FFFF;
				end
				4: begin
					supply = 8191;
					hyst   = 1023;
					deb    = 32'd0;
				end
				5: begin
					supply = $urandom_range(0, 8191);
					hyst   = $urandom_range(0, 1023);
					deb    = $urandom_range(0, 20);
				end
				6: begin
					supply = $urandom_range(600, 8191);
					hyst   = $urandom_range(0, 300);
					deb    = $urandom();
				end
				default: begin
					supply = $urandom_range(600, 8191);
					hyst   = $urandom_range(0, 300);
					deb    = $urandom_range(0, 20);
				end
			endcase
			apply_settings(supply, hyst, deb, dirty);
			// run close to the time wrap once, elsewhere from a random base
			clock_ms = (set == 6) ? 32'hFFFF_FF00 : $urandom();
			no_idle  = (set == 5);
			n = 0;
			while (n < ITEMS_PER_SET) begin
				// receiver holds off once while the sender keeps offering
				if (set == 1 && n >= 40 && !rx_hold_req)
					rx_hold_req = 1'b1;
				if ($urandom_range(99) < 15) begin
					send_sample(MV_W'($urandom_range(8191)), 1'($urandom_range(1)),
						($urandom_range(1) != 0) ? $urandom() : clock_ms);
					n++;
				end else begin
					pos = $urandom_range(3);
					len = $urandom_range(1, 12);
					if ($urandom_range(9) == 0)
						clock_ms += $urandom_range(0, 1000);
					for (int k = 0; k < len && n < ITEMS_PER_SET; k++) begin
						clock_ms += $urandom_range(0, 3);
						if (pos == 0 && $urandom_range(4) == 0)
							send_sample(MV_W'($urandom_range(8191)), 1'b0, clock_ms);
						else
							send_sample(pick_mv(pos), 1'b1, clock_ms);
						n++;
					end
				end
			end
		end
		no_idle = 1'b0;

		// drain, then let the pipeline settle before the verdict
		wait_drained();
		repeat (5) @(negedge clk);

		$display("Ran %0d samples over %0d settings, %0d result words checked,",
			samples_sent, settings_used + 1, results_seen);
		$display("%0d positions debounced to stable, %0d mismatches.",
			positions_debounced, failures);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
